[rtl/bbc_pkg.sv]
// box blur core package: state encoding, default sizes and register indexes
// no dependencies
`timescale 1ns / 1ps
package bbc_pkg;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_RADIUS_DEF = 7;
    localparam int COL_W      = 12;
    localparam int ROW_W      = 14;
    localparam int RAD_W      = 4;
    localparam int IDX_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

    localparam logic OP_PIXEL = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_TAIL,
        S_DIV,
        S_OUT
    } t_state;
endpackage

[rtl/bbc_ram.sv]
// generic simple dual port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module bbc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/box_blur_clamped_edges_core.sv]
// box blur with clamped edges: top level, ring line store in bbc_ram
// depends on bbc_pkg and bbc_ram
// an item that releases no output is taken while idle; one that releases an output
// walks the window with one line store read per window pixel, passes a tail state,
// then runs the serial divider at one bit a cycle (SUM_W = 16 at default size)
// the output state also waits while the previous result is still stalled
// the output register lets the next request in while a result waits
// synchronous active-low reset clears counters, state and config to 640x480, r=1
`timescale 1ns / 1ps
module box_blur_clamped_edges_core #(
    parameter int MAX_WIDTH  = bbc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = bbc_pkg::MAX_RADIUS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bbc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_op,
    input  logic [7:0]                     i_red_in,
    input  logic [7:0]                     i_green_in,
    input  logic [7:0]                     i_blue_in,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [7:0]                     o_red_out,
    output logic [7:0]                     o_green_out,
    output logic [7:0]                     o_blue_out,
    output logic                           o_frame_last
);
    localparam int RING   = 2 * MAX_RADIUS + 2;
    localparam int SLOT_W = $clog2(RING);
    localparam int DEPTH  = RING * MAX_WIDTH;
    localparam int AW     = $clog2(DEPTH);
    localparam int KMAX   = 2 * MAX_RADIUS + 1;
    localparam int AREA_W = $clog2(KMAX * KMAX + 1);
    localparam int SUM_W  = $clog2(255 * KMAX * KMAX + 1);
    localparam int CNT_W  = $clog2(SUM_W + 1);
    localparam int COL_W  = bbc_pkg::COL_W;
    localparam int ROW_W  = bbc_pkg::ROW_W;
    localparam int RAD_W  = bbc_pkg::RAD_W;
    localparam int IDX_W  = bbc_pkg::IDX_W;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        slot_inc = (int'(s) == RING - 1) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [ROW_W-1:0] clamp_row(input logic [ROW_W-1:0] base,
                                                   input logic signed [IDX_W-1:0] off,
                                                   input logic [ROW_W-1:0] hi);
        logic signed [ROW_W+1:0] v;
        v = $signed({2'b00, base}) + (ROW_W+2)'(off);
        if (v < 0) clamp_row = '0;
        else if (v > $signed({2'b00, hi})) clamp_row = hi;
        else clamp_row = v[ROW_W-1:0];
    endfunction

    function automatic logic [COL_W-1:0] clamp_col(input logic [COL_W-1:0] base,
                                                   input logic signed [IDX_W-1:0] off,
                                                   input logic [COL_W-1:0] hi);
        logic signed [COL_W+1:0] v;
        v = $signed({2'b00, base}) + (COL_W+2)'(off);
        if (v < 0) clamp_col = '0;
        else if (v > $signed({2'b00, hi})) clamp_col = hi;
        else clamp_col = v[COL_W-1:0];
    endfunction

    bbc_pkg::t_state r_state, n_state;

    logic [10:0]      r_cfg_w;
    logic [12:0]      r_cfg_h;
    logic [2:0]       r_cfg_r;
    logic [COL_W-1:0] eff_w, w_m1;
    logic [ROW_W-1:0] eff_h, h_m1;
    logic [RAD_W-1:0] eff_r;

    logic [COL_W-1:0]  r_ic, r_oc, n_ic, n_oc;
    logic [ROW_W-1:0]  r_ir, r_or, n_ir, n_or;
    logic [SLOT_W-1:0] r_isl, r_osl, n_isl, n_osl;

    logic signed [IDX_W-1:0] r_wi, r_wj, neg_r;
    logic [ROW_W-1:0]        r_crow, start_row, next_row;
    logic [SLOT_W-1:0]       r_rslot, start_slot;
    logic [ROW_W-1:0]        row_diff;
    logic [AREA_W-1:0]       r_area;
    logic [SUM_W-1:0]        r_acc [3];
    logic [AREA_W-1:0]       r_rem [3];
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_rd_pend;

    logic          accept, ready, pix_we, can_load, last;
    logic [AW-1:0] waddr, raddr;
    logic [23:0]   rdata;
    logic [COL_W-1:0] rd_col;
    logic [ROW_W-1:0] need_row;
    logic [COL_W-1:0] need_col;

    logic       r_ov, r_last;
    logic [7:0] r_red, r_green, r_blue;

    // effective geometry
    always_comb begin
        if (r_cfg_w == '0) eff_w = COL_W'(1);
        else if (int'(r_cfg_w) > MAX_WIDTH) eff_w = COL_W'(MAX_WIDTH);
        else eff_w = COL_W'(r_cfg_w);
        eff_h = (r_cfg_h == '0) ? ROW_W'(1) : ROW_W'(r_cfg_h);
        eff_r = (int'(r_cfg_r) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(r_cfg_r);
        w_m1  = eff_w - 1'b1;
        h_m1  = eff_h - 1'b1;
        neg_r = -$signed({1'b0, eff_r});
    end

    assign accept = i_valid && !o_stall;

    // counter normalisation, pixel write and readiness on a request, output counter step on a load
    always_comb begin
        n_ic = r_ic; n_ir = r_ir; n_isl = r_isl;
        n_oc = r_oc; n_or = r_or; n_osl = r_osl;
        pix_we   = 1'b0;
        waddr    = '0;
        ready    = 1'b0;
        need_row = '0;
        need_col = '0;
        last     = (r_or == h_m1) && (r_oc == w_m1);
        if (r_state == bbc_pkg::S_IDLE) begin
            if (n_ic >= eff_w) begin
                n_ic = '0; n_ir = n_ir + 1'b1; n_isl = slot_inc(n_isl);
            end
            if (n_ir > eff_h) n_ir = eff_h;
            if (n_oc >= eff_w) begin
                n_oc = '0; n_or = n_or + 1'b1; n_osl = slot_inc(n_osl);
            end
            if (n_or >= eff_h) begin
                n_ic = '0; n_ir = '0; n_isl = '0;
                n_oc = '0; n_or = '0; n_osl = '0;
            end
            waddr = AW'(n_isl) * AW'(MAX_WIDTH) + AW'(n_ic);
            if (accept && i_op == bbc_pkg::OP_PIXEL && n_ir < eff_h) begin
                pix_we = 1'b1;
                n_ic = n_ic + 1'b1;
                if (n_ic >= eff_w) begin
                    n_ic = '0; n_ir = n_ir + 1'b1; n_isl = slot_inc(n_isl);
                end
            end
            need_row = n_or + ROW_W'(eff_r);
            if (need_row > h_m1) need_row = h_m1;
            need_col = n_oc + COL_W'(eff_r);
            if (need_col > w_m1) need_col = w_m1;
            ready = (n_ir > need_row) || (n_ir == need_row && n_ic > need_col);
            if (!accept) begin
                n_ic = r_ic; n_ir = r_ir; n_isl = r_isl;
                n_oc = r_oc; n_or = r_or; n_osl = r_osl;
                ready = 1'b0;
            end
        end else if (r_state == bbc_pkg::S_OUT && can_load) begin
            if (last) begin
                n_ic = '0; n_ir = '0; n_isl = '0;
                n_oc = '0; n_or = '0; n_osl = '0;
            end else begin
                n_oc = r_oc + 1'b1;
                if (n_oc >= eff_w) begin
                    n_oc = '0; n_or = r_or + 1'b1; n_osl = slot_inc(r_osl);
                end
            end
        end
    end

    // first window row and its ring slot, next window row, read address and output load condition
    always_comb begin
        start_row  = clamp_row(n_or, neg_r, h_m1);
        row_diff   = n_or - start_row;
        if (ROW_W'(n_osl) >= row_diff) start_slot = n_osl - SLOT_W'(row_diff);
        else start_slot = SLOT_W'(ROW_W'(n_osl) + ROW_W'(RING) - row_diff);
        next_row   = clamp_row(r_or, r_wi + 1'b1, h_m1);
        rd_col     = clamp_col(r_oc, r_wj, w_m1);
        raddr      = AW'(r_rslot) * AW'(MAX_WIDTH) + AW'(rd_col);
        can_load   = !r_ov || !i_stall;
    end

    bbc_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (waddr),
        .i_wdata ({i_red_in, i_green_in, i_blue_in}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bbc_pkg::S_IDLE: if (ready) n_state = bbc_pkg::S_SUM;
            bbc_pkg::S_SUM: begin
                if (r_wi == $signed({1'b0, eff_r}) && r_wj == $signed({1'b0, eff_r})) begin
                    n_state = bbc_pkg::S_TAIL;
                end
            end
            bbc_pkg::S_TAIL: n_state = bbc_pkg::S_DIV;
            bbc_pkg::S_DIV:  if (r_cnt == CNT_W'(1)) n_state = bbc_pkg::S_OUT;
            bbc_pkg::S_OUT:  if (can_load) n_state = bbc_pkg::S_IDLE;
            default:         n_state = bbc_pkg::S_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        case (r_state)
            bbc_pkg::S_IDLE: o_stall = 1'b0;
            default:         o_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bbc_pkg::S_IDLE;
            r_cfg_w <= 11'd640;
            r_cfg_h <= 13'd480;
            r_cfg_r <= 3'd1;
            r_ic <= '0; r_ir <= '0; r_isl <= '0;
            r_oc <= '0; r_or <= '0; r_osl <= '0;
            r_rd_pend <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bbc_pkg::REG_WIDTH:  r_cfg_w <= i_cfg_data[10:0];
                    bbc_pkg::REG_HEIGHT: r_cfg_h <= i_cfg_data[12:0];
                    bbc_pkg::REG_RADIUS: r_cfg_r <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            r_ic <= n_ic; r_ir <= n_ir; r_isl <= n_isl;
            r_oc <= n_oc; r_or <= n_or; r_osl <= n_osl;
            r_rd_pend <= (r_state == bbc_pkg::S_SUM);
            if (r_state == bbc_pkg::S_OUT && can_load) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
        end
    end

    // window walk, accumulation, serial divide and output register load
    always_ff @(posedge i_clk) begin
        logic [AREA_W:0] t;
        if (r_state == bbc_pkg::S_IDLE && ready) begin
            r_wi    <= neg_r;
            r_wj    <= neg_r;
            r_crow  <= start_row;
            r_rslot <= start_slot;
            r_area  <= AREA_W'((2 * eff_r + 1) * (2 * eff_r + 1));
            r_cnt   <= CNT_W'(SUM_W);
            for (int c = 0; c < 3; c++) begin
                r_acc[c] <= '0;
                r_rem[c] <= '0;
            end
        end
        if (r_state == bbc_pkg::S_SUM) begin
            if (r_wj == $signed({1'b0, eff_r})) begin
                r_wj   <= neg_r;
                r_wi   <= r_wi + 1'b1;
                r_crow <= next_row;
                if (next_row != r_crow) r_rslot <= slot_inc(r_rslot);
            end else begin
                r_wj <= r_wj + 1'b1;
            end
        end
        if (r_rd_pend) begin
            r_acc[0] <= r_acc[0] + SUM_W'(rdata[23:16]);
            r_acc[1] <= r_acc[1] + SUM_W'(rdata[15:8]);
            r_acc[2] <= r_acc[2] + SUM_W'(rdata[7:0]);
        end
        if (r_state == bbc_pkg::S_DIV) begin
            r_cnt <= r_cnt - 1'b1;
            for (int c = 0; c < 3; c++) begin
                t = {r_rem[c], r_acc[c][SUM_W-1]};
                if (t >= {1'b0, r_area}) begin
                    r_rem[c] <= AREA_W'(t - {1'b0, r_area});
                    r_acc[c] <= {r_acc[c][SUM_W-2:0], 1'b1};
                end else begin
                    r_rem[c] <= t[AREA_W-1:0];
                    r_acc[c] <= {r_acc[c][SUM_W-2:0], 1'b0};
                end
            end
        end
        if (r_state == bbc_pkg::S_OUT && can_load) begin
            r_red   <= r_acc[0][7:0];
            r_green <= r_acc[1][7:0];
            r_blue  <= r_acc[2][7:0];
            r_last  <= last;
        end
    end

    assign o_valid      = r_ov;
    assign o_red_out    = r_red;
    assign o_green_out  = r_green;
    assign o_blue_out   = r_blue;
    assign o_frame_last = r_last;

    // a result appears only after the output state
    a_out_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == bbc_pkg::S_OUT))
        else $error("output loaded outside output state");

    // the line store is never written while a window is being read
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != bbc_pkg::S_IDLE) |-> !pix_we)
        else $error("line store written during window walk");

    // read data is only expected right after a window read
    a_rd_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> $past(r_state == bbc_pkg::S_SUM))
        else $error("read pending without a window read");
endmodule
